[sv/afrc_pkg.sv]
// ----------------------------------------------------------------------------
// Addressed frame receiver package
// Shared types, codes and the CRC-16/MODBUS byte update function.
// ----------------------------------------------------------------------------
package afrc_pkg;

    // Register reset values
    localparam logic [7:0]  DeviceAddressRst = 8'h01;
    localparam logic [7:0]  StartByteRst     = 8'h55;
    localparam logic [7:0]  EndByteRst       = 8'hAA;
    localparam logic [10:0] MaxLengthRst     = 11'd1024;
    localparam logic        CrcCheckRst      = 1'b1;

    // CRC-16/MODBUS constants
    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_DEVICE_ADDRESS = 3'd0,
        REG_START_BYTE     = 3'd1,
        REG_END_BYTE       = 3'd2,
        REG_MAX_LENGTH     = 3'd3,
        REG_CRC_CHECK      = 3'd4
    } reg_index_t;

    // Parser phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ADDR   = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_DATA   = 3'd4,
        PH_CRC_LO = 3'd5,
        PH_CRC_HI = 3'd6,
        PH_END    = 3'd7
    } phase_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_DONE    = 2'd1,
        ST_BAD_LEN = 2'd2,
        ST_BAD_CRC = 2'd3
    } status_t;

    // Configuration register bundle
    typedef struct packed {
        logic [7:0]  device_address;
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [10:0] max_length;
        logic        crc_check_enable;
    } cfg_t;

    // One byte of CRC-16/MODBUS, unrolled over the eight bits.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CrcPoly;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

[sv/addressed_frame_receiver_crc16_unit.sv]
// ----------------------------------------------------------------------------
// Addressed frame receiver with CRC-16/MODBUS
// Parses start, address, length, payload, CRC and end bytes of a frame.
// ----------------------------------------------------------------------------
// The receiver takes one byte per clock cycle while it is not stalled by
// back-pressure, and gives one result transfer per byte, in order: an input
// register holds the byte, and the parser logic, including the eight-bit
// unrolled CRC update, writes the result register. Each result carries
// the status (busy, frame complete, bad length, CRC mismatch) and, for
// payload bytes, the byte and its index; a complete frame reports its length.
// While a result waits the input register can still take one byte, so the
// input stalls only once both stages are full. Registers on the APB port are
// meant to be written while no byte is in flight.
module addressed_frame_receiver_crc16_unit #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] payload_byte, [17:8] payload_index,
                                   // [28:18] frame_length, [31:29] zero
    output logic [2:0]  m_tuser,   // [1:0] status, [2] payload_valid
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    afrc_pkg::cfg_t cfg;
    logic           byte_valid;
    logic [7:0]     byte_data;
    logic           byte_ready;

    afrc_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afrc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_ready (byte_ready)
    );

    afrc_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_ready (byte_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

[sv/afrc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the receiver's five settings.
// ----------------------------------------------------------------------------
module afrc_cfg_regs (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output afrc_pkg::cfg_t   cfg
);

    afrc_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    // Register writes; addresses beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address   <= afrc_pkg::DeviceAddressRst;
            cfg_reg.start_byte       <= afrc_pkg::StartByteRst;
            cfg_reg.end_byte         <= afrc_pkg::EndByteRst;
            cfg_reg.max_length       <= afrc_pkg::MaxLengthRst;
            cfg_reg.crc_check_enable <= afrc_pkg::CrcCheckRst;
        end else if (wr_en) begin
            case (reg_sel)
                afrc_pkg::REG_DEVICE_ADDRESS: cfg_reg.device_address   <= pwdata[7:0];
                afrc_pkg::REG_START_BYTE:     cfg_reg.start_byte       <= pwdata[7:0];
                afrc_pkg::REG_END_BYTE:       cfg_reg.end_byte         <= pwdata[7:0];
                afrc_pkg::REG_MAX_LENGTH:     cfg_reg.max_length       <= pwdata[10:0];
                afrc_pkg::REG_CRC_CHECK:      cfg_reg.crc_check_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (reg_sel)
            afrc_pkg::REG_DEVICE_ADDRESS: prdata = {24'd0, cfg_reg.device_address};
            afrc_pkg::REG_START_BYTE:     prdata = {24'd0, cfg_reg.start_byte};
            afrc_pkg::REG_END_BYTE:       prdata = {24'd0, cfg_reg.end_byte};
            afrc_pkg::REG_MAX_LENGTH:     prdata = {21'd0, cfg_reg.max_length};
            afrc_pkg::REG_CRC_CHECK:      prdata = {31'd0, cfg_reg.crc_check_enable};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

[sv/afrc_in_stage.sv]
// ----------------------------------------------------------------------------
// Input register stage
// Registers each received byte ahead of the parser.
// ----------------------------------------------------------------------------
module afrc_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    output logic       byte_valid,
    output logic [7:0] byte_data,
    input  logic       byte_ready
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // The stage takes a new transfer when it is empty or being drained.
    assign s_tready   = !valid_reg || byte_ready;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            data_reg <= s_tdata;
        end
    end

endmodule

[sv/afrc_parser.sv]
// ----------------------------------------------------------------------------
// Frame parser
// Phase tracking, length check, CRC update and the result register.
// ----------------------------------------------------------------------------
module afrc_parser #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  afrc_pkg::cfg_t   cfg,
    input  logic             byte_valid,
    input  logic [7:0]       byte_data,
    output logic             byte_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,  // [7:0] payload_byte, [17:8] payload_index,
                                       // [28:18] frame_length, [31:29] zero
    output logic [2:0]       m_tuser   // [1:0] status, [2] payload_valid
);

    localparam logic [15:0] MaxPayload = 16'(MAX_PAYLOAD);

    afrc_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]       declared_reg, declared_next;
    logic [10:0]       count_reg, count_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        crc_lo_reg, crc_lo_next;

    afrc_pkg::status_t status_next, status_reg;
    logic              pvalid_next, pvalid_reg;
    logic [7:0]        pbyte_next, pbyte_reg;
    logic [9:0]        pindex_next, pindex_reg;
    logic [10:0]       flen_next, flen_reg;

    logic              out_valid_reg;
    logic              advance;
    logic [15:0]       max_len_ext;
    logic [15:0]       limit;
    logic [15:0]       len_full;
    logic [10:0]       count_inc;

    // One byte moves in whenever the result register is free or draining.
    assign byte_ready = !out_valid_reg || m_tready;
    assign advance    = byte_valid && byte_ready;

    assign max_len_ext = {5'd0, cfg.max_length};
    assign limit       = (max_len_ext > MaxPayload) ? MaxPayload : max_len_ext;
    assign len_full    = {byte_data, declared_reg[7:0]};
    assign count_inc   = count_reg + 11'd1;

    // Next state and result for the byte at the parser input.
    always_comb begin
        phase_next    = phase_reg;
        declared_next = declared_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_lo_next   = crc_lo_reg;
        status_next   = afrc_pkg::ST_BUSY;
        pvalid_next   = 1'b0;
        pbyte_next    = 8'd0;
        pindex_next   = 10'd0;
        flen_next     = 11'd0;
        case (phase_reg)
            afrc_pkg::PH_IDLE: begin
                if (byte_data == cfg.start_byte) begin
                    phase_next = afrc_pkg::PH_ADDR;
                end
            end
            afrc_pkg::PH_ADDR: begin
                // The address match wins over a repeated start byte.
                if (byte_data == cfg.device_address) begin
                    phase_next = afrc_pkg::PH_LEN_LO;
                end else if (byte_data != cfg.start_byte) begin
                    phase_next = afrc_pkg::PH_IDLE;
                end
            end
            afrc_pkg::PH_LEN_LO: begin
                count_next    = 11'd0;
                declared_next = {8'd0, byte_data};
                phase_next    = afrc_pkg::PH_LEN_HI;
            end
            afrc_pkg::PH_LEN_HI: begin
                declared_next = len_full;
                if (len_full == 16'd0 || len_full > limit) begin
                    status_next = afrc_pkg::ST_BAD_LEN;
                    phase_next  = afrc_pkg::PH_IDLE;
                end else begin
                    crc_next   = afrc_pkg::CrcInit;
                    phase_next = afrc_pkg::PH_DATA;
                end
            end
            afrc_pkg::PH_DATA: begin
                pvalid_next = 1'b1;
                pbyte_next  = byte_data;
                pindex_next = count_reg[9:0];
                crc_next    = afrc_pkg::crc16_update(crc_reg, byte_data);
                count_next  = count_inc;
                if ({5'd0, count_inc} >= declared_reg) begin
                    phase_next = afrc_pkg::PH_CRC_LO;
                end
            end
            afrc_pkg::PH_CRC_LO: begin
                crc_lo_next = byte_data;
                phase_next  = afrc_pkg::PH_CRC_HI;
            end
            afrc_pkg::PH_CRC_HI: begin
                if (cfg.crc_check_enable && crc_reg != {byte_data, crc_lo_reg}) begin
                    status_next = afrc_pkg::ST_BAD_CRC;
                    phase_next  = afrc_pkg::PH_IDLE;
                end else begin
                    phase_next = afrc_pkg::PH_END;
                end
            end
            afrc_pkg::PH_END: begin
                // A wrong end byte drops the frame without a frame-complete status.
                if (byte_data == cfg.end_byte) begin
                    status_next = afrc_pkg::ST_DONE;
                    flen_next   = declared_reg[10:0];
                end
                phase_next = afrc_pkg::PH_IDLE;
            end
            default: begin
                phase_next = afrc_pkg::PH_IDLE;
            end
        endcase
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= afrc_pkg::PH_IDLE;
            declared_reg <= 16'd0;
            count_reg    <= 11'd0;
            crc_reg      <= afrc_pkg::CrcInit;
            crc_lo_reg   <= 8'd0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            declared_reg <= declared_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            crc_lo_reg   <= crc_lo_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (byte_ready) begin
            out_valid_reg <= byte_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= status_next;
            pvalid_reg <= pvalid_next;
            pbyte_reg  <= pbyte_next;
            pindex_reg <= pindex_next;
            flen_reg   <= flen_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, flen_reg, pindex_reg, pbyte_reg};
    assign m_tuser  = {pvalid_reg, status_reg};

    // A payload byte is never reported together with an end-of-frame status.
    a_payload_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && pvalid_reg) |-> (status_reg == afrc_pkg::ST_BUSY))
        else $error("payload byte carries a non-busy status");

    // The frame length is only reported with a complete frame.
    a_flen_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && status_reg != afrc_pkg::ST_DONE) |-> (flen_reg == 11'd0))
        else $error("frame length reported without a complete frame");

    // While in the data phase the count stays below the declared length.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == afrc_pkg::PH_DATA) |-> ({5'd0, count_reg} < declared_reg))
        else $error("payload count reached the declared length inside data phase");

    // A data byte leads either to more data or to the CRC low byte.
    a_data_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && phase_reg == afrc_pkg::PH_DATA) |=>
        (phase_reg == afrc_pkg::PH_DATA || phase_reg == afrc_pkg::PH_CRC_LO))
        else $error("illegal phase after a data byte");

endmodule
